// ===== rtl/pyr_pkg.sv =====
// Shared types, constants and helper functions for the packed YUV 4:2:2 to RGB converter.
package pyr_pkg;

    localparam int PYR_QUEUE_DEPTH = 4;

    localparam int BYTE_W  = 8;
    localparam int PIXEL_W = 24;
    localparam int COEF_W  = 18;
    localparam int DIFF_W  = 9;
    localparam int ACC_W   = 27;

    // Q16 coefficients, rounded to the nearest integer.
    localparam logic signed [COEF_W-1:0] COEF_RV = 18'sd92242;
    localparam logic signed [COEF_W-1:0] COEF_GU = 18'sd22643;
    localparam logic signed [COEF_W-1:0] COEF_GV = 18'sd46983;
    localparam logic signed [COEF_W-1:0] COEF_BU = 18'sd116589;

    localparam logic signed [DIFF_W-1:0] CHROMA_OFFSET = 9'sd128;

    localparam logic FMT_RGB888 = 1'b0;
    localparam logic FMT_RGB565 = 1'b1;

    typedef enum logic [1:0] {
        PH_U  = 2'd0,
        PH_Y0 = 2'd1,
        PH_V  = 2'd2,
        PH_Y1 = 2'd3
    } phase_t;

    // One pixel to convert: luma and the shared chroma pair.
    typedef struct packed {
        logic [BYTE_W-1:0] y;
        logic [BYTE_W-1:0] u;
        logic [BYTE_W-1:0] v;
    } job_t;

    // Handshake between the front end and the queue.
    typedef struct packed {
        logic push;
        job_t job;
    } job_req_t;

    function automatic logic signed [DIFF_W-1:0] chroma_diff(input logic [BYTE_W-1:0] c);
        return $signed({1'b0, c}) - CHROMA_OFFSET;
    endfunction

    // Floor the Q16 sum to an integer and clamp it to one byte.
    function automatic logic [BYTE_W-1:0] clip_q16(input logic signed [ACC_W-1:0] acc);
        logic [BYTE_W-1:0] res;
        if (acc[ACC_W-1]) begin
            res = '0;
        end else if (acc[ACC_W-2:16+BYTE_W] != '0) begin
            res = '1;
        end else begin
            res = acc[16+BYTE_W-1:16];
        end
        return res;
    endfunction

    function automatic logic [PIXEL_W-1:0] pack_pixel(
        input logic              fmt,
        input logic [BYTE_W-1:0] r,
        input logic [BYTE_W-1:0] g,
        input logic [BYTE_W-1:0] b
    );
        logic [PIXEL_W-1:0] res;
        if (fmt == FMT_RGB565) begin
            res = {8'd0, r[7:3], g[7:2], b[7:3]};
        end else begin
            res = {r, g, b};
        end
        return res;
    endfunction

endpackage

// ===== rtl/pyr_front.sv =====
// Front end: tracks the byte phase, holds the pair bytes and issues one job per pixel.
module pyr_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     accept,
    input  logic [pyr_pkg::BYTE_W-1:0] data_byte,
    input  logic                     line_start,
    output pyr_pkg::job_req_t        req
);
    import pyr_pkg::*;

    phase_t            phase_reg, phase_next;
    phase_t            cur_phase;
    logic [BYTE_W-1:0] held_u_reg, held_u_next;
    logic [BYTE_W-1:0] held_y0_reg, held_y0_next;
    logic [BYTE_W-1:0] held_v_reg, held_v_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_U;
            held_u_reg  <= '0;
            held_y0_reg <= '0;
            held_v_reg  <= '0;
        end else begin
            phase_reg   <= phase_next;
            held_u_reg  <= held_u_next;
            held_y0_reg <= held_y0_next;
            held_v_reg  <= held_v_next;
        end
    end

    always_comb begin
        // A line start drops any half-finished pair and treats this byte as U.
        cur_phase    = line_start ? PH_U : phase_reg;
        phase_next   = phase_reg;
        held_u_next  = held_u_reg;
        held_y0_next = held_y0_reg;
        held_v_next  = held_v_reg;
        req.push     = 1'b0;
        req.job.y    = held_y0_reg;
        req.job.u    = held_u_reg;
        req.job.v    = data_byte;
        if (accept) begin
            case (cur_phase)
                PH_U: begin
                    held_u_next = data_byte;
                    phase_next  = PH_Y0;
                end
                PH_Y0: begin
                    held_y0_next = data_byte;
                    phase_next   = PH_V;
                end
                PH_V: begin
                    held_v_next = data_byte;
                    req.push    = 1'b1;
                    phase_next  = PH_Y1;
                end
                PH_Y1: begin
                    req.push   = 1'b1;
                    req.job.y  = data_byte;
                    req.job.v  = held_v_reg;
                    phase_next = PH_U;
                end
                default: begin
                    phase_next = PH_U;
                end
            endcase
        end
    end

endmodule

// ===== rtl/pyr_queue.sv =====
// Short first-word-fall-through queue of conversion jobs between front and back end.
module pyr_queue #(
    parameter int DEPTH = pyr_pkg::PYR_QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  pyr_pkg::job_req_t req,
    output logic              full,
    output logic              out_valid,
    input  logic              out_ready,
    output pyr_pkg::job_t     out_job
);
    import pyr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign out_valid = (count_reg != '0);
    assign out_job   = slot_reg[rd_ptr_reg];
    assign do_push   = req.push && !full;
    assign do_pop    = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= req.job;
        end
    end

endmodule

// ===== rtl/pyr_back.sv =====
// Back end: two-stage color conversion (products, then sums, clip and packing).
module pyr_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        job_valid,
    output logic                        job_ready,
    input  pyr_pkg::job_t               job,
    input  logic                        fmt,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [pyr_pkg::PIXEL_W-1:0] m_tdata
);
    import pyr_pkg::*;

    logic signed [DIFF_W-1:0] du;
    logic signed [DIFF_W-1:0] dv;

    logic                     a_valid_reg, a_valid_next;
    logic [BYTE_W-1:0]        a_y_reg;
    logic signed [ACC_W-1:0]  a_rv_reg;
    logic signed [ACC_W-1:0]  a_gu_reg;
    logic signed [ACC_W-1:0]  a_gv_reg;
    logic signed [ACC_W-1:0]  a_bu_reg;

    logic signed [ACC_W-1:0]  ys;
    logic signed [ACC_W-1:0]  sum_r;
    logic signed [ACC_W-1:0]  sum_g;
    logic signed [ACC_W-1:0]  sum_b;
    logic [PIXEL_W-1:0]       pixel;

    logic                     m_valid_reg, m_valid_next;
    logic [PIXEL_W-1:0]       m_data_reg;
    logic                     m_free;

    assign m_free    = !m_valid_reg || m_tready;
    assign job_ready = !a_valid_reg || m_free;
    assign du        = chroma_diff(job.u);
    assign dv        = chroma_diff(job.v);

    always_comb begin
        a_valid_next = a_valid_reg;
        m_valid_next = m_valid_reg;
        if (job_ready) begin
            a_valid_next = job_valid;
        end
        if (m_free) begin
            m_valid_next = a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Stage A: the four constant products.
    always_ff @(posedge aclk) begin
        if (job_valid && job_ready) begin
            a_y_reg  <= job.y;
            a_rv_reg <= dv * COEF_RV;
            a_gu_reg <= du * COEF_GU;
            a_gv_reg <= dv * COEF_GV;
            a_bu_reg <= du * COEF_BU;
        end
    end

    assign ys    = $signed({3'b000, a_y_reg, 16'h0000});
    assign sum_r = ys + a_rv_reg;
    assign sum_g = ys - a_gu_reg - a_gv_reg;
    assign sum_b = ys + a_bu_reg;
    assign pixel = pack_pixel(fmt, clip_q16(sum_r), clip_q16(sum_g), clip_q16(sum_b));

    // Stage B doubles as the output register.
    always_ff @(posedge aclk) begin
        if (a_valid_reg && m_free) begin
            m_data_reg <= pixel;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== rtl/packed_yuv422_to_rgb_core.sv =====
// Top level of the packed YUV 4:2:2 to RGB888 / RGB565 converter.
//
// The slave channel takes one stream byte per word in the order U, Y0, V, Y1.
// s_tuser marks a line start: that byte is taken as U and any half-finished
// pair is dropped. The word carrying V yields the pixel for Y0, the word
// carrying Y1 the pixel for Y1; U and Y0 words yield nothing.
// The master channel gives one pixel per word, RGB888 as R G B from the high
// byte down, or RGB565 in the low 16 bits, as chosen by the format register
// (cfg_wr_en / cfg_wr_data, written while the block is idle).
// The job from an accepted V or Y1 word enters the queue at the accepting edge,
// the queue head feeds the product stage register, and sum, clip and packing
// land in the output register that drives m_tvalid. The slave channel takes
// one word per cycle while the queue is not full, and every stage can take a
// new job in each cycle while the receiver does not stall.
// When the receiver stalls, the output register and product stage hold, the
// job queue fills, and s_tready falls only once the queue is full.
// Reset clears the byte phase to U, the held bytes, the queue and the format
// (RGB888); s_tready is high in the first cycle after reset.
module packed_yuv422_to_rgb_core #(
    parameter int QUEUE_DEPTH = pyr_pkg::PYR_QUEUE_DEPTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // data_byte[7:0]
    input  logic                        s_tuser,   // line_start
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [pyr_pkg::PIXEL_W-1:0] m_tdata,   // pixel[23:0]
    input  logic                        cfg_wr_en,
    input  logic                        cfg_wr_data  // output_format
);
    import pyr_pkg::*;

    logic     fmt_reg, fmt_next;
    logic     s_accept;
    logic     q_full;
    logic     q_valid;
    logic     q_ready;
    job_t     q_job;
    job_req_t req;

    assign s_tready = !q_full;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        fmt_next = cfg_wr_en ? cfg_wr_data : fmt_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg <= FMT_RGB888;
        end else begin
            fmt_reg <= fmt_next;
        end
    end

    pyr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (s_accept),
        .data_byte  (s_tdata),
        .line_start (s_tuser),
        .req        (req)
    );

    pyr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (req),
        .full      (q_full),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_job   (q_job)
    );

    pyr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (q_valid),
        .job_ready (q_ready),
        .job       (q_job),
        .fmt       (fmt_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== rtl/pyr_checker.sv =====
// Port-level checks for the converter, bound to the top level.
module pyr_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [pyr_pkg::PIXEL_W-1:0] m_tdata,
    input logic                        cfg_wr_en,
    input logic                        cfg_wr_data
);
    import pyr_pkg::*;

    logic fmt_reg, fmt_next;

    // Mirror of the format register as seen on the configuration port.
    always_comb begin
        fmt_next = cfg_wr_en ? cfg_wr_data : fmt_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg <= FMT_RGB888;
        end else begin
            fmt_reg <= fmt_next;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready right after reset");

    a_rgb565_top_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (fmt_reg == FMT_RGB565) |-> (m_tdata[23:16] == 8'd0))
        else $error("RGB565 pixel has nonzero upper byte");

endmodule

bind packed_yuv422_to_rgb_core pyr_checker u_pyr_checker (.*);

// ===== dv/yuv_pixel_checker.sv =====
// Checker for the packed YUV 4:2:2 to RGB converter: predicts each pixel and compares.
`timescale 1ns / 1ps

module yuv_pixel_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [7:0]                  s_tdata,
    input  logic                        s_tuser,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [pyr_pkg::PIXEL_W-1:0] m_tdata,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_wr_data,
    output int                          mismatches,
    output int                          pixels_waiting,
    output int                          pixels_checked
);
    import pyr_pkg::*;

    // Q16 color matrix terms.
    localparam int K_RV = 92242;
    localparam int K_GU = 22643;
    localparam int K_GV = 46983;
    localparam int K_BU = 116589;

    phase_t                 byte_slot;
    logic [7:0]             u_hold;
    logic [7:0]             y0_hold;
    logic [7:0]             v_hold;
    logic                   rgb_format;
    logic [PIXEL_W-1:0]     pixel_fifo[$];
    int                     err_count;

    assign mismatches = err_count;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        err_count++;
    endtask

    function automatic logic [7:0] clamp_q16(input int acc);
        int whole;
        if (acc < 0) begin
            return 8'd0;
        end
        whole = acc >>> 16;
        if (whole > 255) begin
            return 8'd255;
        end
        return whole[7:0];
    endfunction

    function automatic logic [PIXEL_W-1:0] yuv_to_pixel(
        input logic [7:0] y,
        input logic [7:0] u,
        input logic [7:0] v,
        input logic       fmt
    );
        int         luma;
        int         du;
        int         dv;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        luma = int'(y) * 65536;
        du   = int'(u) - 128;
        dv   = int'(v) - 128;
        r    = clamp_q16(luma + K_RV * dv);
        g    = clamp_q16(luma - K_GU * du - K_GV * dv);
        b    = clamp_q16(luma + K_BU * du);
        if (fmt == FMT_RGB565) begin
            return {8'd0, r[7:3], g[7:2], b[7:3]};
        end
        return {r, g, b};
    endfunction

    // A line start forces the byte to be taken as U, dropping any half pair.
    function automatic void take_byte(input logic [7:0] b, input logic line_start);
        phase_t slot;
        slot = line_start ? PH_U : byte_slot;
        case (slot)
            PH_U: begin
                u_hold    = b;
                byte_slot = PH_Y0;
            end
            PH_Y0: begin
                y0_hold   = b;
                byte_slot = PH_V;
            end
            PH_V: begin
                v_hold = b;
                pixel_fifo.push_back(yuv_to_pixel(y0_hold, u_hold, b, rgb_format));
                byte_slot = PH_Y1;
            end
            default: begin
                pixel_fifo.push_back(yuv_to_pixel(b, u_hold, v_hold, rgb_format));
                byte_slot = PH_U;
            end
        endcase
    endfunction

    always @(posedge aclk) begin
        logic [PIXEL_W-1:0] want;
        if (!aresetn) begin
            byte_slot  = PH_U;
            u_hold     = '0;
            y0_hold    = '0;
            v_hold     = '0;
            rgb_format = FMT_RGB888;
            err_count  = 0;
            pixel_fifo.delete();
            pixels_checked <= 0;
        end else begin
            if (cfg_wr_en) begin
                rgb_format = cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                take_byte(s_tdata, s_tuser);
            end
            if (m_tvalid && m_tready) begin
                if (pixel_fifo.size() == 0) begin
                    report_mismatch($sformatf("unexpected pixel word %06h", m_tdata));
                end else begin
                    want = pixel_fifo.pop_front();
                    if (m_tdata !== want) begin
                        report_mismatch($sformatf("pixel %06h, expected %06h",
                                                  m_tdata, want));
                    end
                end
                pixels_checked <= pixels_checked + 1;
            end
        end
        pixels_waiting <= pixel_fifo.size();
    end

endmodule

// ===== dv/testbench.sv =====
// Top of the converter testbench: clock, reset, stimulus, output stalls and the verdict.
`timescale 1ns / 1ps

module testbench;
    import pyr_pkg::*;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;
    logic               s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [PIXEL_W-1:0] m_tdata;
    logic               cfg_wr_en;
    logic               cfg_wr_data;

    int mismatches;
    int pixels_waiting;
    int pixels_checked;

    int bytes_sent;
    int line_starts;
    int holds_done;
    bit gaps_on;
    bit stalls_on;
    bit hold_req;

    packed_yuv422_to_rgb_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    yuv_pixel_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .mismatches     (mismatches),
        .pixels_waiting (pixels_waiting),
        .pixels_checked (pixels_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d pixels still expected.", pixels_waiting);
        $display("*** FAILED ***");
        $finish;
    end

    // Output side: random short stalls, plus one long hold-off on request.
    initial begin
        int n;
        m_tready = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                for (n = 0; n < 300; n++) begin
                    @(posedge aclk);
                end
                holds_done++;
            end else if (stalls_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 6);
                repeat (n) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic send_word(input logic [7:0] data, input logic ls);
        int gap;
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= ls;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        if (ls) begin
            line_starts++;
        end
    endtask

    // Stop sending, let every expected pixel come out, then let the clock run on
    // before returning, in case a U or Y0 word is still inside.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pixels_waiting != 0);
        repeat (6) @(posedge aclk);
    endtask

    task automatic set_format(input logic fmt);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= fmt;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic send_pair(input logic ls, input logic [7:0] u, input logic [7:0] y0,
                             input logic [7:0] v, input logic [7:0] y1);
        send_word(u, ls);
        send_word(y0, 1'b0);
        send_word(v, 1'b0);
        send_word(y1, 1'b0);
    endtask

    // Random byte, leaning toward the extremes so that clipping is common.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic stream_line();
        int kind;
        int count;
        int i;
        kind = $urandom_range(0, 9);
        case (kind)
            0: begin
                // Noise: random bytes with random line-start flags.
                count = $urandom_range(1, 8);
                for (i = 0; i < count; i++) begin
                    send_word(pick_byte(), 1'($urandom_range(0, 1)));
                end
            end
            1: begin
                // Line cut short in the middle of a pair.
                count = 4 * $urandom_range(1, 8) - $urandom_range(1, 3);
                for (i = 0; i < count; i++) begin
                    send_word(pick_byte(), i == 0);
                end
            end
            default: begin
                // Well-formed line; now and then the line-start flag is missing.
                count = 4 * $urandom_range(1, 16);
                for (i = 0; i < count; i++) begin
                    send_word(pick_byte(), i == 0 && kind != 2);
                end
            end
        endcase
    endtask

    initial begin
        int p;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = FMT_RGB888;
        bytes_sent  = 0;
        line_starts = 0;
        holds_done  = 0;
        gaps_on     = 1'b0;
        stalls_on   = 1'b0;
        hold_req    = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words. The stream first starts without a line start.
        send_pair(1'b0, 8'h80, 8'h10, 8'h80, 8'hEB);
        send_pair(1'b1, 8'h00, 8'h00, 8'h00, 8'hFF);
        send_pair(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'h00);
        // Line start after U and Y0: the half pair is dropped.
        send_word(8'h55, 1'b1);
        send_word(8'hAA, 1'b0);
        // Line start where V would come.
        send_word(8'h12, 1'b1);
        send_word(8'h34, 1'b0);
        send_word(8'h56, 1'b0);
        send_pair(1'b1, 8'h9A, 8'hBC, 8'hDE, 8'h01);
        // Format switch between the first and second half of a pair.
        send_word(8'h3C, 1'b1);
        send_word(8'hC3, 1'b0);
        set_format(FMT_RGB565);
        send_word(8'h7E, 1'b0);
        send_word(8'h81, 1'b0);
        send_pair(1'b1, 8'h00, 8'hFF, 8'hFF, 8'h00);

        for (p = 0; p < 6; p++) begin
            set_format(p[0] ? FMT_RGB565 : FMT_RGB888);
            if (p == 1) begin
                // Long output hold-off while a long line keeps coming in.
                gaps_on  = 1'b0;
                hold_req = 1'b1;
                send_pair(1'b1, pick_byte(), pick_byte(), pick_byte(), pick_byte());
                repeat (31) send_pair(1'b0, pick_byte(), pick_byte(), pick_byte(),
                                      pick_byte());
            end
            while (bytes_sent < 24 + 288 * (p + 1)) begin
                gaps_on   = (p != 5) && ($urandom_range(0, 3) != 0);
                stalls_on = (p != 5) && ($urandom_range(0, 3) != 0);
                stream_line();
                if (p != 5 && $urandom_range(0, 24) == 0) begin
                    wait_idle();
                end
            end
        end

        wait_idle();
        repeat (10) @(posedge aclk);
        $display("Sent %0d stream bytes with %0d line starts; compared %0d pixels.",
                 bytes_sent, line_starts, pixels_checked);
        $display("Both output formats, mid-pair realignment and %0d long output hold-off.",
                 holds_done);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
